### rtl/lzwd_pkg.sv
// shared types and codes for the lzw variable width decoder
// no dependencies; imported by the controller, datapath and top level
package lzwd_pkg;

   // request kinds carried on req_tuser
   localparam logic [1:0] CMD_PUSH    = 2'd0;
   localparam logic [1:0] CMD_PULL    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // response kinds carried on rsp_tuser
   localparam logic [2:0] RSP_BYTE     = 3'd0;
   localparam logic [2:0] RSP_NEED     = 3'd1;
   localparam logic [2:0] RSP_END      = 3'd2;
   localparam logic [2:0] RSP_ACCEPTED = 3'd3;
   localparam logic [2:0] RSP_REFUSED  = 3'd4;

   // reserved codes
   localparam int CODE_WIDEN = 256;
   localparam int CODE_CLEAR = 257;
   localparam int CODE_END   = 258;
   localparam int FIRST_FREE = 259;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_CODE,
      FSM_END_OUT,
      FSM_WALK,
      FSM_WALK_RD,
      FSM_ADD,
      FSM_POP_RD,
      FSM_POP_OUT
   } fsm_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_PUSH,
      OP_RESTART,
      OP_EMIT,
      OP_CODE,
      OP_WALK,
      OP_WALK_RD,
      OP_ADD,
      OP_POP_RD,
      OP_POP_OUT
   } dp_op_type;

   typedef enum logic [1:0] {
      KIND_DATA,
      KIND_WIDEN,
      KIND_CLEAR,
      KIND_END
   } code_kind_type;

   typedef struct packed {
      dp_op_type   op;
      logic [2:0]  emit_status;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0]    cmd;
      logic          depth_nz;
      logic          ended;
      logic          bits_ok;
      code_kind_type kind;
      logic          walk_more;
      logic          out_full;
   } dp_stat_type;

endpackage

### rtl/lzwd_ram.sv
// generic single port ram with registered read
// no dependencies
module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule

### rtl/lzwd_ctrl.sv
// sequencing state machine of the lzw decoder
// depends on lzwd_pkg; drives datapath commands from datapath status
module lzwd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  lzwd_pkg::dp_stat_type stat,
   output lzwd_pkg::dp_cmd_type  cmd
);
   import lzwd_pkg::*;

   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_tvalid) state_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            if (!stat.out_full) begin
               if (stat.cmd == CMD_PULL) begin
                  if (stat.depth_nz)   state_in = FSM_POP_RD;
                  else if (stat.ended) state_in = FSM_IDLE;
                  else                 state_in = FSM_CODE;
               end else begin
                  state_in = FSM_IDLE;
               end
            end
         end
         FSM_CODE: begin
            if (!stat.bits_ok) begin
               if (!stat.out_full) state_in = FSM_IDLE;
            end else begin
               case (stat.kind)
                  KIND_END:  state_in = FSM_END_OUT;
                  KIND_DATA: state_in = FSM_WALK;
                  default:   state_in = FSM_CODE;
               endcase
            end
         end
         FSM_END_OUT: begin
            if (!stat.out_full) state_in = FSM_IDLE;
         end
         FSM_WALK: begin
            state_in = stat.walk_more ? FSM_WALK_RD : FSM_ADD;
         end
         FSM_WALK_RD: state_in = FSM_WALK;
         FSM_ADD:     state_in = FSM_POP_RD;
         FSM_POP_RD:  state_in = FSM_POP_OUT;
         FSM_POP_OUT: begin
            if (!stat.out_full) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready      = 1'b0;
      cmd.op          = OP_NONE;
      cmd.emit_status = RSP_NEED;
      case (state_ff)
         FSM_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = OP_LATCH;
         end
         FSM_EXEC: begin
            if (!stat.out_full) begin
               case (stat.cmd)
                  CMD_PUSH:    cmd.op = OP_PUSH;
                  CMD_RESTART: cmd.op = OP_RESTART;
                  CMD_PULL: begin
                     if (!stat.depth_nz && stat.ended) begin
                        cmd.op          = OP_EMIT;
                        cmd.emit_status = RSP_END;
                     end
                  end
                  default: cmd.op = OP_EMIT;
               endcase
            end
         end
         FSM_CODE: begin
            if (stat.bits_ok)        cmd.op = OP_CODE;
            else if (!stat.out_full) cmd.op = OP_EMIT;
         end
         FSM_END_OUT: begin
            if (!stat.out_full) begin
               cmd.op          = OP_EMIT;
               cmd.emit_status = RSP_END;
            end
         end
         FSM_WALK:    cmd.op = OP_WALK;
         FSM_WALK_RD: cmd.op = OP_WALK_RD;
         FSM_ADD:     cmd.op = OP_ADD;
         FSM_POP_RD:  cmd.op = OP_POP_RD;
         FSM_POP_OUT: begin
            if (!stat.out_full) cmd.op = OP_POP_OUT;
         end
         default: cmd.op = OP_NONE;
      endcase
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT || cmd.op == OP_POP_OUT) |-> !stat.out_full)
      else $error("result issued while output register full");
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == FSM_EXEC)
      else $error("accepted beat not executed");
   a_code_bits: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_CODE |-> stat.bits_ok)
      else $error("code taken without enough bits");

endmodule

### rtl/lzwd_datapath.sv
// datapath of the lzw decoder: bit buffer, dictionary and output stack
// depends on lzwd_pkg and lzwd_ram; driven by lzwd_ctrl commands
module lzwd_datapath #(
   parameter int MIN_CODE_BITS = 9,
   parameter int MAX_CODE_BITS = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_tuser,
   input  logic [15:0]           req_tdata,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [7:0]            rsp_tdata,
   output logic [2:0]            rsp_tuser,
   input  lzwd_pkg::dp_cmd_type  cmd,
   output lzwd_pkg::dp_stat_type stat
);
   import lzwd_pkg::*;

   localparam int CW    = MAX_CODE_BITS;
   localparam int NFW   = CW + 1;
   localparam int TABLE = 1 << CW;
   localparam int WW    = $clog2(MAX_CODE_BITS + 1);

   localparam logic [1:0] K_FIRST  = 2'd0;
   localparam logic [1:0] K_NORMAL = 2'd1;
   localparam logic [1:0] K_KWK    = 2'd2;

   // control state
   logic [31:0]    bitbuf_ff, bitbuf_in;
   logic [5:0]     bitcnt_ff, bitcnt_in;
   logic [WW-1:0]  cwidth_ff, cwidth_in;
   logic [CW-1:0]  prevcode_ff, prevcode_in;
   logic [7:0]     prevfc_ff, prevfc_in;
   logic [NFW-1:0] nextfree_ff, nextfree_in;
   logic [NFW-1:0] depth_ff, depth_in;
   logic           first_ff, first_in;
   logic           ended_ff, ended_in;
   logic           full_ff, full_in;
   // payload
   logic [CW-1:0]  walk_ff, walk_in;
   logic [NFW-1:0] guard_ff, guard_in;
   logic [7:0]     fbyte_ff, fbyte_in;
   logic [1:0]     knd_ff, knd_in;
   logic [CW-1:0]  keep_ff, keep_in;
   logic [1:0]     cmd_ff, cmd_in;
   logic [15:0]    word_ff, word_in;
   logic [7:0]     obyte_ff, obyte_in;
   logic [2:0]     ostat_ff, ostat_in;

   // memories
   logic            dict_en, dict_we;
   logic [CW-1:0]   dict_addr;
   logic [CW+7:0]   dict_wdata, dict_rdata;
   logic            stk_en, stk_we;
   logic [CW-1:0]   stk_addr;
   logic [7:0]      stk_wdata, stk_rdata;

   logic [15:0]     code;
   code_kind_type   kind;
   logic            walk_more;

   assign code = 16'(bitbuf_ff >> (6'd32 - 6'(cwidth_ff)));

   always_comb begin
      case (code)
         16'(CODE_WIDEN): kind = KIND_WIDEN;
         16'(CODE_CLEAR): kind = KIND_CLEAR;
         16'(CODE_END):   kind = KIND_END;
         default:         kind = KIND_DATA;
      endcase
   end

   assign walk_more = (walk_ff >= CW'(FIRST_FREE)) && !guard_ff[CW];

   assign stat.cmd       = cmd_ff;
   assign stat.depth_nz  = depth_ff != '0;
   assign stat.ended     = ended_ff;
   assign stat.bits_ok   = bitcnt_ff >= 6'(cwidth_ff);
   assign stat.kind      = kind;
   assign stat.walk_more = walk_more;
   assign stat.out_full  = full_ff;

   always_comb begin
      bitbuf_in   = bitbuf_ff;
      bitcnt_in   = bitcnt_ff;
      cwidth_in   = cwidth_ff;
      prevcode_in = prevcode_ff;
      prevfc_in   = prevfc_ff;
      nextfree_in = nextfree_ff;
      depth_in    = depth_ff;
      first_in    = first_ff;
      ended_in    = ended_ff;
      full_in     = full_ff;
      walk_in     = walk_ff;
      guard_in    = guard_ff;
      fbyte_in    = fbyte_ff;
      knd_in      = knd_ff;
      keep_in     = keep_ff;
      cmd_in      = cmd_ff;
      word_in     = word_ff;
      obyte_in    = obyte_ff;
      ostat_in    = ostat_ff;
      dict_en     = 1'b0;
      dict_we     = 1'b0;
      dict_addr   = walk_ff;
      dict_wdata  = {prevcode_ff, fbyte_ff};
      stk_en      = 1'b0;
      stk_we      = 1'b0;
      stk_addr    = depth_ff[CW-1:0];
      stk_wdata   = prevfc_ff;

      if (rsp_tvalid && rsp_tready) full_in = 1'b0;

      case (cmd.op)
         OP_LATCH: begin
            cmd_in  = req_tuser;
            word_in = req_tdata;
         end
         OP_PUSH: begin
            full_in  = 1'b1;
            obyte_in = '0;
            if (bitcnt_ff <= 6'd16) begin
               bitbuf_in = bitbuf_ff | (32'(word_ff) << (6'd16 - bitcnt_ff));
               bitcnt_in = bitcnt_ff + 6'd16;
               ostat_in  = RSP_ACCEPTED;
            end else begin
               ostat_in  = RSP_REFUSED;
            end
         end
         OP_RESTART: begin
            bitbuf_in   = '0;
            bitcnt_in   = '0;
            cwidth_in   = WW'(MIN_CODE_BITS);
            prevcode_in = '0;
            prevfc_in   = '0;
            nextfree_in = NFW'(FIRST_FREE);
            depth_in    = '0;
            first_in    = 1'b1;
            ended_in    = 1'b0;
            full_in     = 1'b1;
            obyte_in    = '0;
            ostat_in    = RSP_NEED;
         end
         OP_EMIT: begin
            full_in  = 1'b1;
            obyte_in = '0;
            ostat_in = cmd.emit_status;
         end
         OP_CODE: begin
            bitbuf_in = bitbuf_ff << cwidth_ff;
            bitcnt_in = bitcnt_ff - 6'(cwidth_ff);
            guard_in  = '0;
            case (kind)
               KIND_WIDEN: begin
                  if (cwidth_ff < WW'(MAX_CODE_BITS)) cwidth_in = cwidth_ff + 1'b1;
               end
               KIND_CLEAR: begin
                  cwidth_in   = WW'(MIN_CODE_BITS);
                  nextfree_in = NFW'(FIRST_FREE);
                  first_in    = 1'b1;
               end
               KIND_END: ended_in = 1'b1;
               default: begin
                  if (first_ff) begin
                     walk_in = CW'(code[7:0]);
                     keep_in = CW'(code[7:0]);
                     knd_in  = K_FIRST;
                  end else if (17'(code) < 17'(nextfree_ff)) begin
                     walk_in = code[CW-1:0];
                     keep_in = code[CW-1:0];
                     knd_in  = K_NORMAL;
                  end else begin
                     // previous string plus its own first byte
                     walk_in = prevcode_ff;
                     keep_in = code[CW-1:0];
                     knd_in  = K_KWK;
                     if (!depth_ff[CW]) begin
                        stk_en    = 1'b1;
                        stk_we    = 1'b1;
                        stk_wdata = prevfc_ff;
                        depth_in  = depth_ff + 1'b1;
                     end
                  end
               end
            endcase
         end
         OP_WALK: begin
            if (walk_more) begin
               dict_en = 1'b1;
            end else begin
               fbyte_in = walk_ff[7:0];
               if (!depth_ff[CW]) begin
                  stk_en    = 1'b1;
                  stk_we    = 1'b1;
                  stk_wdata = walk_ff[7:0];
                  depth_in  = depth_ff + 1'b1;
               end
            end
         end
         OP_WALK_RD: begin
            walk_in  = dict_rdata[CW+7:8];
            guard_in = guard_ff + 1'b1;
            if (!depth_ff[CW]) begin
               stk_en    = 1'b1;
               stk_we    = 1'b1;
               stk_wdata = dict_rdata[7:0];
               depth_in  = depth_ff + 1'b1;
            end
         end
         OP_ADD: begin
            prevcode_in = keep_ff;
            case (knd_ff)
               K_FIRST: begin
                  prevfc_in = fbyte_ff;
                  first_in  = 1'b0;
               end
               K_NORMAL: begin
                  prevfc_in  = fbyte_ff;
                  dict_wdata = {prevcode_ff, fbyte_ff};
               end
               default: dict_wdata = {prevcode_ff, prevfc_ff};
            endcase
            if (knd_ff != K_FIRST && !nextfree_ff[CW]) begin
               dict_en     = 1'b1;
               dict_we     = 1'b1;
               dict_addr   = nextfree_ff[CW-1:0];
               nextfree_in = nextfree_ff + 1'b1;
            end
         end
         OP_POP_RD: begin
            stk_en   = 1'b1;
            stk_addr = CW'(depth_ff - 1'b1);
            depth_in = depth_ff - 1'b1;
         end
         OP_POP_OUT: begin
            full_in  = 1'b1;
            obyte_in = stk_rdata;
            ostat_in = RSP_BYTE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bitbuf_ff   <= '0;
         bitcnt_ff   <= '0;
         cwidth_ff   <= WW'(MIN_CODE_BITS);
         prevcode_ff <= '0;
         prevfc_ff   <= '0;
         nextfree_ff <= NFW'(FIRST_FREE);
         depth_ff    <= '0;
         first_ff    <= 1'b1;
         ended_ff    <= 1'b0;
         full_ff     <= 1'b0;
      end else begin
         bitbuf_ff   <= bitbuf_in;
         bitcnt_ff   <= bitcnt_in;
         cwidth_ff   <= cwidth_in;
         prevcode_ff <= prevcode_in;
         prevfc_ff   <= prevfc_in;
         nextfree_ff <= nextfree_in;
         depth_ff    <= depth_in;
         first_ff    <= first_in;
         ended_ff    <= ended_in;
         full_ff     <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff  <= walk_in;
      guard_ff <= guard_in;
      fbyte_ff <= fbyte_in;
      knd_ff   <= knd_in;
      keep_ff  <= keep_in;
      cmd_ff   <= cmd_in;
      word_ff  <= word_in;
      obyte_ff <= obyte_in;
      ostat_ff <= ostat_in;
   end

   assign rsp_tvalid = full_ff;
   assign rsp_tdata  = obyte_ff;
   assign rsp_tuser  = ostat_ff;

   // prefix and suffix per entry
   lzwd_ram #(.WIDTH(CW + 8), .DEPTH(TABLE)) u_dict (
      .clock (clock),
      .en    (dict_en),
      .we    (dict_we),
      .addr  (dict_addr),
      .wdata (dict_wdata),
      .rdata (dict_rdata)
   );

   lzwd_ram #(.WIDTH(8), .DEPTH(TABLE)) u_stack (
      .clock (clock),
      .en    (stk_en),
      .we    (stk_we),
      .addr  (stk_addr),
      .wdata (stk_wdata),
      .rdata (stk_rdata)
   );

   a_depth: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= NFW'(TABLE))
      else $error("stack depth past table size");
   a_bitcnt: assert property (@(posedge clock) disable iff (reset)
      bitcnt_ff <= 6'd32)
      else $error("bit count past buffer size");
   a_width: assert property (@(posedge clock) disable iff (reset)
      cwidth_ff >= WW'(MIN_CODE_BITS) && cwidth_ff <= WW'(MAX_CODE_BITS))
      else $error("code width out of range");

endmodule

### rtl/lzw_variable_width_decoder_unit.sv
// lzw variable width decoder, top level
// each request beat yields one result beat; a pull pops a held byte while the stack holds one;
// else, unless ended, it skips widen and clear codes and returns need when short of bits, or
// walks a data code's dictionary chain onto the stack first; an end code or ended pull gives end
// one beat in flight at a time; a waiting result stalls
// reset: synchronous, clears control state; ram contents are undefined until written
module lzw_variable_width_decoder_unit #(
   parameter int MIN_CODE_BITS = 9,
   parameter int MAX_CODE_BITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] input_word
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [2:0]  rsp_tuser    // [2:0] status
);
   import lzwd_pkg::*;

   // command and status between controller and datapath
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // sequencer: accepts a beat only when idle, waits for a free output register
   lzwd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (dp_stat),
      .cmd        (dp_cmd)
   );

   // bit buffer, dictionary ram, output stack ram and result register
   lzwd_datapath #(
      .MIN_CODE_BITS (MIN_CODE_BITS),
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (dp_cmd),
      .stat       (dp_stat)
   );

endmodule

### test/lzw_variable_width_decoder_unit_tb.sv
// testbench for the lzw variable width decoder unit
// drives push, pull and restart beats on the request stream and checks every response
// against an in-bench decoder model; depends on lzwd_pkg and the unit's top level
module lzw_variable_width_decoder_unit_tb;
   import lzwd_pkg::*;

   localparam int MIN_BITS   = 9;
   localparam int MAX_BITS   = 15;
   localparam int TBL_SIZE   = 1 << MAX_BITS;
   localparam int TBL_MASK   = TBL_SIZE - 1;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] status;
   } rsp_beat_type;

   // decoder model and queue of responses still owed by the unit
   class lzw_scoreboard;
      logic [31:0] buf_bits;
      int unsigned buf_count;
      int unsigned width;
      int unsigned prev_code;
      logic [7:0]  prev_first;
      int unsigned next_free;
      logic [14:0] prefix_tbl [TBL_SIZE];
      logic [7:0]  suffix_tbl [TBL_SIZE];
      logic [7:0]  byte_stack [TBL_SIZE];
      int unsigned depth;
      bit          first_pending;
      bit          ended;
      rsp_beat_type pending_rsp [$];
      int mismatches;
      int checked;
      int bytes_seen;
      int ends_seen;

      function void clear_state();
         buf_bits = 0; buf_count = 0; width = MIN_BITS; prev_code = 0;
         prev_first = 0; next_free = FIRST_FREE; depth = 0;
         first_pending = 1; ended = 0;
      endfunction

      function new();
         clear_state();
         mismatches = 0; checked = 0; bytes_seen = 0; ends_seen = 0;
      endfunction

      function void stack_byte(logic [7:0] b);
         if (depth < TBL_SIZE) begin
            byte_stack[depth] = b;
            depth++;
         end
      endfunction

      // walk a prefix chain onto the stack, last byte first
      function logic [7:0] unroll(int unsigned c);
         int unsigned guard;
         guard = 0;
         c = c & TBL_MASK;
         while (c >= FIRST_FREE && guard < TBL_SIZE) begin
            stack_byte(suffix_tbl[c]);
            c = prefix_tbl[c];
            guard++;
         end
         c = c & 8'hff;
         stack_byte(c[7:0]);
         return c[7:0];
      endfunction

      function void grow_dict(int unsigned pre, logic [7:0] suf);
         if (next_free < TBL_SIZE) begin
            prefix_tbl[next_free] = pre[14:0];
            suffix_tbl[next_free] = suf;
            next_free++;
         end
      endfunction

      function void note_request(logic [1:0] cmd, logic [15:0] word);
         rsp_beat_type r;
         int unsigned code;
         logic [7:0] f;
         r.out_byte = 0;
         r.status = RSP_NEED;
         if (cmd == CMD_PUSH) begin
            if (buf_count <= 16) begin
               buf_bits = buf_bits | (32'(word) << (16 - buf_count));
               buf_count += 16;
               r.status = RSP_ACCEPTED;
            end else begin
               r.status = RSP_REFUSED;
            end
         end else if (cmd == CMD_RESTART) begin
            clear_state();
         end else if (cmd == CMD_PULL) begin
            if (depth == 0 && !ended) begin
               while (buf_count >= width) begin
                  code = buf_bits >> (32 - width);
                  buf_bits = buf_bits << width;
                  buf_count -= width;
                  if (code == CODE_WIDEN) begin
                     if (width < MAX_BITS) width++;
                     continue;
                  end
                  if (code == CODE_CLEAR) begin
                     width = MIN_BITS; next_free = FIRST_FREE; first_pending = 1;
                     continue;
                  end
                  if (code == CODE_END) begin
                     ended = 1;
                     break;
                  end
                  if (first_pending) begin
                     code = code & 8'hff;
                     prev_first = unroll(code);
                     first_pending = 0;
                  end else if (code < next_free) begin
                     f = unroll(code);
                     grow_dict(prev_code, f);
                     prev_first = f;
                  end else begin
                     stack_byte(prev_first);
                     void'(unroll(prev_code));
                     grow_dict(prev_code, prev_first);
                  end
                  prev_code = code & TBL_MASK;
                  break;
               end
            end
            if (depth > 0) begin
               depth--;
               r.out_byte = byte_stack[depth];
               r.status = RSP_BYTE;
            end else if (ended) begin
               r.status = RSP_END;
            end
         end
         pending_rsp.push_back(r);
      endfunction

      function void check_response(logic [7:0] b, logic [2:0] s);
         rsp_beat_type e;
         checked++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat byte=%h status=%0d", b, s);
            return;
         end
         e = pending_rsp.pop_front();
         if (s == RSP_BYTE) bytes_seen++;
         if (s == RSP_END) ends_seen++;
         if (e.status !== s || e.out_byte !== b) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected byte=%h status=%0d, got byte=%h status=%0d",
                        e.out_byte, e.status, b, s);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = 0;
   logic [1:0]  req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [7:0]  rsp_tdata;
   logic [2:0]  rsp_tuser;

   lzw_scoreboard board = new();
   bit quiet_phase = 0;    // no idling on either side while set
   int items_sent = 0;

   always #6 clock = ~clock;

   lzw_variable_width_decoder_unit #(.MIN_CODE_BITS(MIN_BITS), .MAX_CODE_BITS(MAX_BITS)) u_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   // response side: random stalls, sample on the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata, rsp_tuser);
   end
   always @(negedge clock) begin
      rsp_tready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 14);
   end

   // one request beat; optional random idle beforehand
   task automatic send_beat(logic [1:0] cmd, logic [15:0] word);
      do @(negedge clock); while (!quiet_phase && $urandom_range(99) < 14);
      req_tvalid <= 1; req_tuser <= cmd; req_tdata <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(cmd, word);
      items_sent++;
      @(negedge clock);
      req_tvalid <= 0;
   endtask

   task automatic wait_drained();
      while (board.pending_rsp.size() != 0) @(negedge clock);
   endtask

   // pull until the bit buffer can take another word
   task automatic make_room();
      while (board.buf_count > 16 && !board.ended) send_beat(CMD_PULL, 0);
   endtask

   // code stream packer: codes go MSB first into 16-bit words
   logic [63:0] pack_bits;
   int          pack_count;
   int          cur_width;
   int          nfree;

   task automatic put_code(int unsigned code, int w);
      pack_bits = (pack_bits << w) | 64'(code);
      pack_count += w;
      while (pack_count >= 16) begin
         make_room();
         send_beat(CMD_PUSH, 16'(pack_bits >> (pack_count - 16)));
         pack_count -= 16;
         // drain bytes as the stream goes; extra pulls are harmless
         repeat (2) send_beat(CMD_PULL, 0);
      end
   endtask

   task automatic flush_codes();
      if (pack_count > 0) begin
         make_room();
         send_beat(CMD_PUSH, 16'(pack_bits << (16 - pack_count)));
      end
      pack_count = 0;
      pack_bits = 0;
   endtask

   // well-formed stream with random content, widen, clear and end codes
   task automatic send_stream(int ncodes);
      int unsigned c;
      int first;
      send_beat(CMD_RESTART, 0);
      cur_width = MIN_BITS; nfree = FIRST_FREE; first = 1;
      pack_bits = 0; pack_count = 0;
      for (int i = 0; i < ncodes; i++) begin
         case ($urandom_range(19))
            0: begin
               put_code(CODE_WIDEN, cur_width);
               if (cur_width < MAX_BITS) cur_width++;
            end
            1: begin
               put_code(CODE_CLEAR, cur_width);
               cur_width = MIN_BITS; nfree = FIRST_FREE; first = 1;
            end
            default: begin
               if (first) c = $urandom_range(255);
               else if ($urandom_range(3) == 0) c = nfree;  // repeated-string case
               else if ($urandom_range(1)) c = $urandom_range(255);
               else c = $urandom_range(nfree - 1, 255);
               if (c == CODE_WIDEN || c == CODE_CLEAR || c == CODE_END) c = 65;
               if (c >= (1 << cur_width)) c = $urandom_range(255);
               put_code(c, cur_width);
               if (!first && nfree < TBL_SIZE) nfree++;
               first = 0;
            end
         endcase
      end
      if ($urandom_range(3) != 0) put_code(CODE_END, cur_width);
      flush_codes();
      for (int k = 0; k < 12; k++) send_beat(CMD_PULL, 0);
   endtask

   initial begin
      logic [1:0] cmd_pick;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: extremes of the word, every command, refused push
      send_beat(CMD_PULL, 0);
      send_beat(CMD_UNUSED, 16'hffff);
      send_beat(CMD_PUSH, 16'hffff);
      send_beat(CMD_PUSH, 16'h0000);
      send_beat(CMD_PUSH, 16'h5a5a);
      send_beat(CMD_PULL, 0);
      send_beat(CMD_PULL, 0);
      send_beat(CMD_RESTART, 0);
      // first code past 255, then repeated-string code
      pack_bits = 0; pack_count = 0; cur_width = MIN_BITS;
      put_code(300, 9); put_code(259, 9); put_code(CODE_WIDEN, 9);
      put_code(65, 10); put_code(1023, 10);
      // clear followed at once by end
      put_code(CODE_CLEAR, 10); put_code(CODE_END, 9);
      flush_codes();
      repeat (6) send_beat(CMD_PULL, 0);
      send_beat(CMD_PUSH, 16'h1234);  // push after the end code
      send_beat(CMD_PULL, 0);
      // sender holds off until every response is in
      wait_drained();
      // random streams; a quiet stretch in the middle
      while (items_sent < 1200) begin
         quiet_phase = (items_sent > 500 && items_sent < 700);
         if ($urandom_range(7) == 0) begin
            // no pulls in the random burst so no code walks into an unwritten entry
            for (int k = 0; k < 6; k++) begin
               cmd_pick = 2'($urandom_range(3));
               if (cmd_pick == CMD_PULL) cmd_pick = CMD_UNUSED;
               send_beat(cmd_pick, 16'($urandom));
            end
         end else begin
            send_stream($urandom_range(4, 30));
         end
      end
      quiet_phase = 0;
      wait_drained();
      repeat (50) @(negedge clock);
      $display("covered %0d request beats, %0d responses, %0d decoded bytes, %0d end statuses",
               items_sent, board.checked, board.bytes_seen, board.ends_seen);
      if (board.mismatches == 0 && board.pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d responses missing", board.mismatches,
                  board.pending_rsp.size());
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("timeout");
      $display("Regression FAIL");
      $finish;
   end
endmodule
